[design/rotation_matrix_to_quaternion_defines.svh]
// Assertion macros shared by the design files.
`ifndef ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define RMQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define RMQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[design/rmq_pkg.sv]
package rmq_pkg;
	localparam int FRAC_BITS_DEF = 14;
	localparam int QW = 16;          // component width
	localparam int RW = 15;          // root bits below saturation
	localparam int RADW = 31;        // radicand and remainder width
	localparam int NL = 4;           // lanes: w, x, y, z
	localparam int NV = 3;           // vector lanes with a sign
	localparam logic [QW-1:0] Q_MAX = 16'h7FFF;

	typedef logic [NL-1:0][RADW-1:0] rad_t;
	typedef logic [NL-1:0][RW-1:0] root_t;

	typedef struct packed {
		logic [NV-1:0] sgn_neg;
		logic [NV-1:0] sgn_zero;
		logic [NL-1:0] sat;
		logic          clamped;
	} side_t;
endpackage

[design/rmq_arg.sv]
module rmq_arg import rmq_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic signed [QW-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22,
	output logic               valid_s1,
	output rad_t               rad_s1,
	output side_t              side_s1
);
	localparam int AW = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
	localparam int XW = (AW + FRAC_BITS > RADW) ? AW + FRAC_BITS : RADW;
	localparam int SH = FRAC_BITS - 2;

	logic signed [AW-1:0] one, e00, e11, e22;
	logic signed [AW-1:0] arg [NL];
	logic signed [QW:0] diff [NV];
	logic [XW-1:0] xw [NL];
	rad_t rad_d;
	side_t side_d;

	always_comb begin
		one = AW'(1) <<< FRAC_BITS;
		e00 = AW'(r00);
		e11 = AW'(r11);
		e22 = AW'(r22);
		arg[0] = e00 + e11 + e22 + one;
		arg[1] = e00 - e11 - e22 + one;
		arg[2] = e11 - e22 - e00 + one;
		arg[3] = e22 - e00 - e11 + one;
		diff[0] = (QW+1)'(r21) - (QW+1)'(r12);
		diff[1] = (QW+1)'(r02) - (QW+1)'(r20);
		diff[2] = (QW+1)'(r10) - (QW+1)'(r01);
		side_d.clamped = 1'b0;
		for (int l = 0; l < NL; l++) begin
			// A negative argument is replaced by zero.
			if (arg[l][AW-1]) begin
				xw[l] = '0;
				side_d.clamped = 1'b1;
			end else begin
				xw[l] = XW'(arg[l][AW-2:0]) << SH;
			end
			side_d.sat[l] = (xw[l] >> (2 * RW)) != '0;
			rad_d[l] = RADW'(xw[l][2*RW-1:0]);
		end
		for (int v = 0; v < NV; v++) begin
			side_d.sgn_neg[v] = diff[v][QW];
			side_d.sgn_zero[v] = (diff[v] == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s1 <= rad_d;
			side_s1 <= side_d;
		end
	end
endmodule

[design/rmq_cell.sv]
module rmq_cell import rmq_pkg::*; #(
	parameter int BIT = 0
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  in_valid,
	input  rad_t  rem_i,
	input  root_t root_i,
	output logic  valid_q,
	output rad_t  rem_q,
	output root_t root_q
);
	logic [RADW-1:0] trial [NL];
	rad_t rem_d;
	root_t root_d;

	// One restoring step: try setting this root bit against the remainder.
	always_comb begin
		for (int l = 0; l < NL; l++) begin
			trial[l] = (RADW'(root_i[l]) << (BIT + 1)) | (RADW'(1) << (2 * BIT));
			if (rem_i[l] >= trial[l]) begin
				rem_d[l] = rem_i[l] - trial[l];
				root_d[l] = root_i[l] | (RW'(1) << BIT);
			end else begin
				rem_d[l] = rem_i[l];
				root_d[l] = root_i[l];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= rem_d;
			root_q <= root_d;
		end
	end
endmodule

[design/rotation_matrix_to_quaternion.sv]
// Rotation matrix to unit quaternion.
// The slave stream carries one 3x3 matrix per request, nine signed elements with
// FRAC_BITS fraction bits. The master stream returns the quaternion w, x, y, z in
// the same format, with tuser set when any square-root argument was negative and
// was clamped to zero.
// The four square roots run side by side through a row of 15 cells, each cell
// settling one root bit, after one stage that forms the arguments and the signs
// and before one output register that applies sign and saturation.
// One request is accepted every cycle while the master side takes results.
// The whole row advances together: when the master side holds a result and
// tready is low, every stage holds and s_axis_tready is low until it is taken.
// Reset clears all valid flags; the row then holds no requests and no result.
`include "rotation_matrix_to_quaternion_defines.svh"
module rotation_matrix_to_quaternion import rmq_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	// r00, r01, r02, r10, r11, r12, r20, r21, r22 from bit 0 up, 16 bits each
	input  logic [143:0]  s_axis_tdata,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	// q_scalar, q_x, q_y, q_z from bit 0 up, 16 bits each
	output logic [63:0]   m_axis_tdata,
	// clamped
	output logic          m_axis_tuser
);
	logic en;
	logic valid_w [RW+1];
	rad_t rem_w [RW+1];
	root_t root_w [RW+1];
	side_t side_s1;
	side_t side_q [1:RW];
	logic [QW-1:0] mag [NL];
	logic [QW-1:0] comp_d [NL];

	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	rmq_arg #(.FRAC_BITS(FRAC_BITS)) u_arg (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (s_axis_tvalid),
		.r00      (s_axis_tdata[15:0]),
		.r01      (s_axis_tdata[31:16]),
		.r02      (s_axis_tdata[47:32]),
		.r10      (s_axis_tdata[63:48]),
		.r11      (s_axis_tdata[79:64]),
		.r12      (s_axis_tdata[95:80]),
		.r20      (s_axis_tdata[111:96]),
		.r21      (s_axis_tdata[127:112]),
		.r22      (s_axis_tdata[143:128]),
		.valid_s1 (valid_w[0]),
		.rad_s1   (rem_w[0]),
		.side_s1  (side_s1)
	);

	assign root_w[0] = '0;

	for (genvar k = 0; k < RW; k++) begin : g_cell
		rmq_cell #(.BIT(RW - 1 - k)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (valid_w[k]),
			.rem_i    (rem_w[k]),
			.root_i   (root_w[k]),
			.valid_q  (valid_w[k+1]),
			.rem_q    (rem_w[k+1]),
			.root_q   (root_w[k+1])
		);
	end

	// Sign and saturation flags travel beside the cells.
	always_ff @(posedge clk) begin
		if (en) begin
			side_q[1] <= side_s1;
			for (int k = 1; k < RW; k++) begin
				side_q[k+1] <= side_q[k];
			end
		end
	end

	always_comb begin
		for (int l = 0; l < NL; l++) begin
			mag[l] = side_q[RW].sat[l] ? Q_MAX : {1'b0, root_w[RW][l]};
		end
		comp_d[0] = mag[0];
		for (int v = 0; v < NV; v++) begin
			if (side_q[RW].sgn_zero[v]) begin
				comp_d[v+1] = '0;
			end else if (side_q[RW].sgn_neg[v]) begin
				comp_d[v+1] = -mag[v+1];
			end else begin
				comp_d[v+1] = mag[v+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (en) begin
			m_axis_tvalid <= valid_w[RW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_axis_tdata <= {comp_d[3], comp_d[2], comp_d[1], comp_d[0]};
			m_axis_tuser <= side_q[RW].clamped;
		end
	end

	`RMQ_ASSERT(a_scalar_pos, !m_axis_tvalid || !m_axis_tdata[15], "scalar part negative")
	`RMQ_ASSERT(a_x_range, !m_axis_tvalid || m_axis_tdata[31:16] != 16'h8000, "x beyond saturation")
	`RMQ_ASSERT(a_ready, s_axis_tready == (!m_axis_tvalid || m_axis_tready), "ready not tied to output")
	`RMQ_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
endmodule

[verif/tb_top.sv]
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import rmq_pkg::*;

	localparam int FRAC = FRAC_BITS_DEF;
	localparam int LATENCY = 17;
	localparam int N_RANDOM = 1300;

	typedef struct packed {
		logic        clamped;
		logic [15:0] q_z;
		logic [15:0] q_y;
		logic [15:0] q_x;
		logic [15:0] q_scalar;
	} quat_t;

	// Integer square root by bit pairs, floor of the true root.
	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res;
		longint unsigned bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic longint half_root(longint a, ref bit neg);
		longint unsigned r;
		if (a < 0) begin
			neg = 1'b1;
			return 0;
		end
		r = int_sqrt(longint'(a) << (FRAC - 2));
		if (r > 32767)
			r = 32767;
		return longint'(r);
	endfunction

	function automatic longint sign_of(longint d);
		return (d > 0) ? 1 : ((d < 0) ? -1 : 0);
	endfunction

	function automatic quat_t predict_quaternion(logic [143:0] m);
		longint e[9];
		longint one;
		longint w, x, y, z;
		bit neg;
		quat_t q;
		for (int i = 0; i < 9; i++)
			e[i] = longint'($signed(m[16*i +: 16]));
		one = longint'(1) << FRAC;
		neg = 1'b0;
		w = half_root(e[0] + e[4] + e[8] + one, neg);
		x = sign_of(e[7] - e[5]) * half_root(e[0] - e[4] - e[8] + one, neg);
		y = sign_of(e[2] - e[6]) * half_root(e[4] - e[8] - e[0] + one, neg);
		z = sign_of(e[3] - e[1]) * half_root(e[8] - e[0] - e[4] + one, neg);
		q.q_scalar = w[15:0];
		q.q_x = x[15:0];
		q.q_y = y[15:0];
		q.q_z = z[15:0];
		q.clamped = neg;
		return q;
	endfunction

	class quat_scoreboard;
		quat_t pending[$];
		int errors;

		function void note_matrix(logic [143:0] m);
			pending.push_back(predict_quaternion(m));
		endfunction

		function void check_result(logic [63:0] data, logic flag);
			quat_t exp_q;
			quat_t got;
			got = {flag, data};
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h", $realtime, got);
				errors++;
				return;
			end
			exp_q = pending.pop_front();
			if (got.q_scalar !== exp_q.q_scalar) begin
				$display("%0t: q_scalar expected %h actual %h", $realtime,
					exp_q.q_scalar, got.q_scalar);
				errors++;
			end
			if (got.q_x !== exp_q.q_x) begin
				$display("%0t: q_x expected %h actual %h", $realtime, exp_q.q_x, got.q_x);
				errors++;
			end
			if (got.q_y !== exp_q.q_y) begin
				$display("%0t: q_y expected %h actual %h", $realtime, exp_q.q_y, got.q_y);
				errors++;
			end
			if (got.q_z !== exp_q.q_z) begin
				$display("%0t: q_z expected %h actual %h", $realtime, exp_q.q_z, got.q_z);
				errors++;
			end
			if (got.clamped !== exp_q.clamped) begin
				$display("%0t: clamped expected %b actual %b", $realtime,
					exp_q.clamped, got.clamped);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [143:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;
	logic m_axis_tuser;

	quat_scoreboard board = new();
	logic [143:0] matrices[$];
	bit long_hold = 1'b0;
	bit hold_done = 1'b0;
	bit sending_done = 1'b0;
	int cycle_count = 0;

	always #5 clk = ~clk;

	rotation_matrix_to_quaternion u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	function automatic logic [15:0] rand_element();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'(FRAC_BITS_DEF == 14 ? 16'h4000 : 16'h0001);
			3: return 16'hC000;
			4: return 16'($signed($urandom_range(0, 32768)) - 16384);
			default: return 16'($urandom);
		endcase
	endfunction

	// Near-rotation matrices: small perturbations of a signed permutation.
	function automatic logic [143:0] rand_rotation();
		logic [143:0] m;
		int perm[3];
		int t, j;
		perm = '{0, 1, 2};
		for (int i = 2; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = perm[i];
			perm[i] = perm[j];
			perm[j] = t;
		end
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++) begin
				t = $signed($urandom_range(0, 4000)) - 2000;
				if (perm[r] == c)
					t += $urandom_range(0, 1) ? 16384 - 2000 : -16384 + 2000;
				m[16*(3*r + c) +: 16] = 16'(t);
			end
		return m;
	endfunction

	task automatic send_matrix(logic [143:0] m);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= m;
		do
			@(posedge clk);
		while (!s_axis_tready);
		board.note_matrix(m);
	endtask

	task automatic idle_sender(int cycles);
		s_axis_tvalid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	initial begin
		logic [143:0] m;
		int burst;
		// Identity, all-zero, extremes and alternating bit patterns.
		matrices.push_back({16'h4000, 16'h0, 16'h0, 16'h0, 16'h4000, 16'h0, 16'h0, 16'h0,
			16'h4000});
		matrices.push_back('0);
		matrices.push_back({9{16'h7FFF}});
		matrices.push_back({9{16'h8000}});
		matrices.push_back({9{16'hAAAA}});
		matrices.push_back({9{16'h5555}});
		// Half-turns about each axis: negative trace, so the scalar part is zero.
		matrices.push_back({16'hC000, 16'h0, 16'h0, 16'h0, 16'hC000, 16'h0, 16'h0, 16'h0,
			16'h4000});
		matrices.push_back({16'hC000, 16'h0, 16'h0, 16'h0, 16'h4000, 16'h0, 16'h0, 16'h0,
			16'hC000});
		matrices.push_back({16'h4000, 16'h0, 16'h0, 16'h0, 16'hC000, 16'h0, 16'h0, 16'h0,
			16'hC000});
		for (int k = 0; k < 14; k++)
			matrices.push_back(k < 7 ? rand_rotation() :
				{rand_element(), rand_element(), rand_element(), rand_element(),
				rand_element(), rand_element(), rand_element(), rand_element(),
				rand_element()});
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (matrices[k])
			send_matrix(matrices[k]);
		for (int n = 0; n < N_RANDOM; ) begin
			burst = $urandom_range(1, 40);
			for (int b = 0; b < burst && n < N_RANDOM; b++, n++) begin
				if ($urandom_range(0, 9) < 7) begin
					m = rand_rotation();
				end else begin
					for (int e = 0; e < 9; e++)
						m[16*e +: 16] = rand_element();
				end
				send_matrix(m);
			end
			if ($urandom_range(0, 2) != 0)
				idle_sender($urandom_range(1, 8));
		end
		s_axis_tvalid <= 1'b0;
		sending_done = 1'b1;
	end

	// One long hold-off once traffic is flowing, so the pipeline fills and stalls.
	initial begin
		wait (arst_n);
		repeat (300) @(posedge clk);
		long_hold = 1'b1;
		repeat (80) @(posedge clk);
		long_hold = 1'b0;
		hold_done = 1'b1;
	end

	always @(posedge clk) begin
		int phase;
		if (arst_n) begin
			phase = $urandom_range(0, 15);
			cycle_count = cycle_count + 1;
			if (long_hold)
				m_axis_tready <= 1'b0;
			else if ((cycle_count % 600) < 150)
				m_axis_tready <= 1'b1;
			else
				m_axis_tready <= phase > 4;
			if (m_axis_tvalid && m_axis_tready)
				board.check_result(m_axis_tdata, m_axis_tuser);
		end
	end

	initial begin
		wait (sending_done && hold_done);
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#2ms;
		$display("RESULT: ERROR");
		$finish;
	end
endmodule
